/* hdl/cji_pkg.sv */
// ---------------------------------------------------------------------------
// cji_pkg
// Shared widths, constants and types of the cubic joint interpolator.
// ---------------------------------------------------------------------------
package cji_pkg;

    localparam int TIME_BITS      = 24;
    localparam int TIME_FRAC_BITS = TIME_BITS - 8;
    localparam int POS_W          = 32;

    localparam int MUL_CH  = 28;
    localparam int MUL_NCH = 4;
    localparam int MUL_XW  = MUL_CH * MUL_NCH;
    localparam int PP_W    = MUL_CH + TIME_BITS + 1;
    localparam int ACC_W   = 136;

    localparam int T3_W = 3 * TIME_BITS;
    localparam int D_W  = T3_W + TIME_FRAC_BITS;
    localparam int Q_W  = POS_W;

    localparam logic [TIME_BITS-1:0] DURATION_RESET = TIME_BITS'(65536);
    localparam logic [POS_W-1:0]     POS_MAX        = {1'b0, {(POS_W-1){1'b1}}};
    localparam logic [POS_W-1:0]     POS_MIN        = {1'b1, {(POS_W-1){1'b0}}};

    typedef struct packed {
        logic signed [POS_W-1:0] p1;
        logic                    zero;
    } t_pside;

    typedef struct packed {
        logic signed [POS_W-1:0] p1;
        logic                    zero;
        logic                    neg;
        logic                    big;
    } t_dside;

    typedef struct packed {
        logic [TIME_BITS-1:0]    t;
        logic [TIME_BITS-1:0]    dur;
        logic signed [POS_W-1:0] p1;
        logic                    zero;
    } t_pctx;

    typedef struct packed {
        logic signed [POS_W-1:0] position;
        logic                    overflow;
    } t_res;

endpackage

/* hdl/cji_mul.sv */
// ---------------------------------------------------------------------------
// cji_mul
// Two-stage multiply-add: wide signed x times unsigned time word plus addend.
// ---------------------------------------------------------------------------
module cji_mul import cji_pkg::*; (
    input  logic                    i_clk,
    input  logic                    i_en,
    input  logic signed [MUL_XW-1:0] i_x,
    input  logic [TIME_BITS-1:0]    i_u,
    input  logic signed [ACC_W-1:0] i_add,
    output logic signed [ACC_W-1:0] o_p
);

    logic signed [PP_W-1:0]  r_pp [MUL_NCH];
    logic signed [ACC_W-1:0] r_add;
    logic signed [ACC_W-1:0] r_p;
    logic signed [ACC_W-1:0] n_p;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < MUL_NCH - 1; i++) begin
                r_pp[i] <= $signed({1'b0, i_x[i*MUL_CH +: MUL_CH]}) * $signed({1'b0, i_u});
            end
            r_pp[MUL_NCH-1] <= $signed(i_x[MUL_XW-1 -: MUL_CH]) * $signed({1'b0, i_u});
            r_add <= i_add;
        end
    end

    always_comb begin
        n_p = r_add;
        for (int i = 0; i < MUL_NCH; i++) begin
            n_p = n_p + (ACC_W'(r_pp[i]) <<< (i * MUL_CH));
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p <= n_p;
        end
    end

    assign o_p = r_p;

endmodule

/* hdl/cji_poly.sv */
// ---------------------------------------------------------------------------
// cji_poly
// Horner evaluation of the scaled numerator N and of T^3.
// ---------------------------------------------------------------------------
module cji_poly import cji_pkg::*; (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_en,
    input  logic                    i_valid,
    input  logic signed [POS_W-1:0] i_p0,
    input  logic signed [POS_W-1:0] i_p1,
    input  logic signed [POS_W-1:0] i_v0,
    input  logic signed [POS_W-1:0] i_v1,
    input  logic [TIME_BITS-1:0]    i_t,
    input  logic [TIME_BITS-1:0]    i_dur,
    output logic                    o_valid,
    output logic signed [ACC_W-1:0] o_n,
    output logic [T3_W-1:0]         o_t3,
    output t_pside                  o_side
);

    localparam int NST = 13;

    logic [NST-1:0]           r_v;
    t_pctx                    r_c [NST];
    logic signed [POS_W:0]    r_sv;
    logic signed [POS_W+1:0]  r_w;
    logic signed [POS_W-1:0]  r_v0;
    logic signed [ACC_W-1:0]  r_kadd;
    logic signed [ACC_W-1:0]  r_ladd;
    logic signed [ACC_W-1:0]  r_eadd;
    logic signed [ACC_W-1:0]  r_kd [2];
    logic signed [ACC_W-1:0]  r_ettd [4];
    logic [T3_W-1:0]          r_t3d [8];
    logic signed [ACC_W-1:0]  w_dp;

    logic signed [ACC_W-1:0] w_k, w_l, w_e, w_t2, w_lt, w_et, w_t3;
    logic signed [ACC_W-1:0] w_h, w_ett, w_g, w_q, w_n;

    assign w_dp = ACC_W'(i_p1) - ACC_W'(i_p0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[NST-2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_c[0]    <= '{t: i_t, dur: i_dur, p1: i_p1, zero: (i_dur == '0)};
            for (int i = 1; i < NST; i++) begin
                r_c[i] <= r_c[i-1];
            end
            r_sv      <= (POS_W+1)'(i_v0) + (POS_W+1)'(i_v1);
            r_w       <= -((POS_W+2)'(i_v0) <<< 1) - (POS_W+2)'(i_v1);
            r_v0      <= i_v0;
            r_kadd    <= -(w_dp <<< (TIME_FRAC_BITS + 1));
            r_ladd    <= (w_dp <<< TIME_FRAC_BITS) + (w_dp <<< (TIME_FRAC_BITS + 1));
            r_eadd    <= ACC_W'(i_p0) <<< TIME_FRAC_BITS;
            r_kd[0]   <= w_k;
            r_kd[1]   <= r_kd[0];
            r_ettd[0] <= w_ett;
            for (int i = 1; i < 4; i++) begin
                r_ettd[i] <= r_ettd[i-1];
            end
            r_t3d[0]  <= w_t3[T3_W-1:0];
            for (int i = 1; i < 8; i++) begin
                r_t3d[i] <= r_t3d[i-1];
            end
        end
    end

    // K = (v0+v1)T - 2F dp, L = (-2v0-v1)T + 3F dp, E = F p0 + v0 t
    cji_mul u_k  (.i_clk, .i_en, .i_x(MUL_XW'(r_sv)), .i_u(r_c[0].dur), .i_add(r_kadd),
                  .o_p(w_k));
    cji_mul u_l  (.i_clk, .i_en, .i_x(MUL_XW'(r_w)), .i_u(r_c[0].dur), .i_add(r_ladd),
                  .o_p(w_l));
    cji_mul u_e  (.i_clk, .i_en, .i_x(MUL_XW'(r_v0)), .i_u(r_c[0].t), .i_add(r_eadd),
                  .o_p(w_e));
    cji_mul u_t2 (.i_clk, .i_en, .i_x(MUL_XW'({1'b0, r_c[0].dur})), .i_u(r_c[0].dur),
                  .i_add('0), .o_p(w_t2));

    cji_mul u_lt (.i_clk, .i_en, .i_x(w_l[MUL_XW-1:0]), .i_u(r_c[2].dur), .i_add('0),
                  .o_p(w_lt));
    cji_mul u_et (.i_clk, .i_en, .i_x(w_e[MUL_XW-1:0]), .i_u(r_c[2].dur), .i_add('0),
                  .o_p(w_et));
    cji_mul u_t3 (.i_clk, .i_en, .i_x(w_t2[MUL_XW-1:0]), .i_u(r_c[2].dur), .i_add('0),
                  .o_p(w_t3));

    // H = K t + L T
    cji_mul u_h  (.i_clk, .i_en, .i_x(r_kd[1][MUL_XW-1:0]), .i_u(r_c[4].t), .i_add(w_lt),
                  .o_p(w_h));
    cji_mul u_ett(.i_clk, .i_en, .i_x(w_et[MUL_XW-1:0]), .i_u(r_c[4].dur), .i_add('0),
                  .o_p(w_ett));

    cji_mul u_g  (.i_clk, .i_en, .i_x(w_h[MUL_XW-1:0]), .i_u(r_c[6].t), .i_add('0),
                  .o_p(w_g));
    cji_mul u_q  (.i_clk, .i_en, .i_x(w_g[MUL_XW-1:0]), .i_u(r_c[8].t), .i_add('0),
                  .o_p(w_q));

    // N = E T^3 + H t^2
    cji_mul u_n  (.i_clk, .i_en, .i_x(r_ettd[3][MUL_XW-1:0]), .i_u(r_c[10].dur), .i_add(w_q),
                  .o_p(w_n));

    assign o_valid = r_v[NST-1];
    assign o_n     = w_n;
    assign o_t3    = r_t3d[7];
    assign o_side  = '{p1: r_c[NST-1].p1, zero: r_c[NST-1].zero};

endmodule

/* hdl/cji_div_step.sv */
// ---------------------------------------------------------------------------
// cji_div_step
// One registered restoring division step, one quotient bit.
// ---------------------------------------------------------------------------
module cji_div_step import cji_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  logic             i_valid,
    input  logic [ACC_W-1:0] i_rem,
    input  logic [ACC_W-1:0] i_ds,
    input  logic [Q_W-1:0]   i_q,
    input  t_dside           i_side,
    output logic             o_valid,
    output logic [ACC_W-1:0] o_rem,
    output logic [ACC_W-1:0] o_ds,
    output logic [Q_W-1:0]   o_q,
    output t_dside           o_side
);

    logic             r_valid;
    logic [ACC_W-1:0] r_rem;
    logic [ACC_W-1:0] r_ds;
    logic [Q_W-1:0]   r_q;
    t_dside           r_side;
    logic             w_ge;

    assign w_ge = (i_rem >= i_ds);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem  <= w_ge ? (i_rem - i_ds) : i_rem;
            r_ds   <= i_ds >> 1;
            r_q    <= {i_q[Q_W-2:0], w_ge};
            r_side <= i_side;
        end
    end

    assign o_valid = r_valid;
    assign o_rem   = r_rem;
    assign o_ds    = r_ds;
    assign o_q     = r_q;
    assign o_side  = r_side;

endmodule

/* hdl/cji_div.sv */
// ---------------------------------------------------------------------------
// cji_div
// Rounding floor division of N by F*T^3 with saturation to 32 bits.
// ---------------------------------------------------------------------------
module cji_div import cji_pkg::*; (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_en,
    input  logic                    i_valid,
    input  logic signed [ACC_W-1:0] i_n,
    input  logic [T3_W-1:0]         i_t3,
    input  t_pside                  i_side,
    output logic                    o_valid,
    output t_res                    o_res
);

    logic [2:0]              r_vd;
    logic signed [ACC_W-1:0] r_m;
    logic [D_W-1:0]          r_d0;
    t_pside                  r_s0;
    logic [ACC_W-1:0]        r_mag;
    logic [D_W-1:0]          r_d1;
    t_dside                  r_s1;
    logic [ACC_W-1:0]        r_rem;
    logic [ACC_W-1:0]        r_ds;
    t_dside                  r_s2;
    logic                    r_vf;
    t_res                    r_res;
    logic                    w_neg;

    logic             w_vld  [Q_W+1];
    logic [ACC_W-1:0] w_rem  [Q_W+1];
    logic [ACC_W-1:0] w_ds   [Q_W+1];
    logic [Q_W-1:0]   w_q    [Q_W+1];
    t_dside           w_side [Q_W+1];

    logic [Q_W-1:0] w_qf;
    t_dside         w_sf;
    logic           w_ovf;
    t_res           n_res;

    assign w_neg = r_m[ACC_W-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vd <= '0;
            r_vf <= 1'b0;
        end else if (i_en) begin
            r_vd <= {r_vd[1:0], i_valid};
            r_vf <= w_vld[Q_W];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            // add half the divisor for round to nearest
            r_m   <= i_n + (ACC_W'({1'b0, i_t3}) <<< (TIME_FRAC_BITS - 1));
            r_d0  <= {i_t3, TIME_FRAC_BITS'(0)};
            r_s0  <= i_side;
            // floor of a negative quotient: ceil of |m| over d
            r_mag <= w_neg ? ((~r_m) + ACC_W'(r_d0)) : r_m;
            r_d1  <= r_d0;
            r_s1  <= '{p1: r_s0.p1, zero: r_s0.zero, neg: w_neg, big: 1'b0};
            r_rem <= r_mag;
            r_ds  <= ACC_W'({r_d1, (Q_W-1)'(0)});
            r_s2  <= '{p1: r_s1.p1, zero: r_s1.zero, neg: r_s1.neg,
                       big: (r_mag >= ACC_W'({r_d1, Q_W'(0)}))};
            r_res <= n_res;
        end
    end

    assign w_vld[0]  = r_vd[2];
    assign w_rem[0]  = r_rem;
    assign w_ds[0]   = r_ds;
    assign w_q[0]    = '0;
    assign w_side[0] = r_s2;

    for (genvar k = 0; k < Q_W; k++) begin : g_step
        cji_div_step u_step (
            .i_clk, .i_rst_n, .i_en,
            .i_valid(w_vld[k]),    .i_rem(w_rem[k]), .i_ds(w_ds[k]),
            .i_q(w_q[k]),          .i_side(w_side[k]),
            .o_valid(w_vld[k+1]),  .o_rem(w_rem[k+1]), .o_ds(w_ds[k+1]),
            .o_q(w_q[k+1]),        .o_side(w_side[k+1])
        );
    end

    assign w_qf  = w_q[Q_W];
    assign w_sf  = w_side[Q_W];
    assign w_ovf = w_sf.big | (w_sf.neg ? (w_qf[Q_W-1] & (|w_qf[Q_W-2:0])) : w_qf[Q_W-1]);

    always_comb begin
        if (w_sf.zero) begin
            n_res = '{position: w_sf.p1, overflow: 1'b0};
        end else if (w_ovf) begin
            n_res = '{position: (w_sf.neg ? POS_MIN : POS_MAX), overflow: 1'b1};
        end else begin
            n_res = '{position: (w_sf.neg ? -w_qf : w_qf), overflow: 1'b0};
        end
    end

    assign o_valid = r_vf;
    assign o_res   = r_res;

endmodule

/* hdl/cji_outq.sv */
// ---------------------------------------------------------------------------
// cji_outq
// Two-entry result queue; decouples the pipeline from output backpressure.
// ---------------------------------------------------------------------------
module cji_outq import cji_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_res i_data,
    input  logic i_ready,
    output logic o_valid,
    output t_res o_data,
    output logic o_room
);

    logic [1:0] r_cnt;
    logic [1:0] n_cnt;
    t_res       r_slot [2];
    t_res       n_slot [2];
    logic       w_pop;
    logic       w_wi;

    assign w_pop = (r_cnt != 2'd0) & i_ready;
    assign w_wi  = 1'(r_cnt - 2'(w_pop));

    always_comb begin
        n_cnt  = r_cnt + 2'(i_push) - 2'(w_pop);
        n_slot = r_slot;
        if (w_pop) begin
            n_slot[0] = r_slot[1];
        end
        if (i_push) begin
            n_slot[w_wi] = i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_slot <= n_slot;
    end

    assign o_valid = (r_cnt != 2'd0);
    assign o_data  = r_slot[0];
    assign o_room  = (r_cnt < 2'd2);

endmodule

/* hdl/cubic_joint_interpolator.sv */
// ---------------------------------------------------------------------------
// cubic_joint_interpolator
// Cubic Hermite joint position at elapsed time t for a move of duration T.
//
//   channel  direction  handshake                   payload
//   cfg      in         i_cfg_we                    i_cfg_wdata (duration)
//   in       in         i_in_valid / o_in_ready     p0, p1, v0, v1, t
//   out      out        o_out_valid / i_out_ready   position, overflow
//
// One transaction per cycle sustained while the output queue has room.
// The pipeline holds 13 polynomial stages and 32 restoring divide steps.
// Synchronous active-low reset clears valid bits and the output queue;
// duration resets to 1.0 s. The whole pipeline stalls only when the
// two-entry output queue is full.
// ---------------------------------------------------------------------------
module cubic_joint_interpolator import cji_pkg::*; (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_cfg_we,
    input  logic [TIME_BITS-1:0]    i_cfg_wdata,
    input  logic                    i_in_valid,
    output logic                    o_in_ready,
    input  logic signed [POS_W-1:0] i_start_position,
    input  logic signed [POS_W-1:0] i_target_position,
    input  logic signed [POS_W-1:0] i_start_velocity,
    input  logic signed [POS_W-1:0] i_end_velocity,
    input  logic [TIME_BITS-1:0]    i_elapsed_time,
    output logic                    o_out_valid,
    input  logic                    i_out_ready,
    output logic signed [POS_W-1:0] o_position,
    output logic                    o_overflow
);

    logic [TIME_BITS-1:0]    r_duration;
    logic                    w_adv;
    logic                    w_pvalid;
    logic signed [ACC_W-1:0] w_n;
    logic [T3_W-1:0]         w_t3;
    t_pside                  w_pside;
    logic                    w_dvalid;
    t_res                    w_dres;
    t_res                    w_ores;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_duration <= DURATION_RESET;
        end else if (i_cfg_we) begin
            r_duration <= i_cfg_wdata;
        end
    end

    cji_poly u_poly (
        .i_clk, .i_rst_n, .i_en(w_adv),
        .i_valid(i_in_valid & w_adv),
        .i_p0(i_start_position), .i_p1(i_target_position),
        .i_v0(i_start_velocity), .i_v1(i_end_velocity),
        .i_t(i_elapsed_time),    .i_dur(r_duration),
        .o_valid(w_pvalid), .o_n(w_n), .o_t3(w_t3), .o_side(w_pside)
    );

    cji_div u_div (
        .i_clk, .i_rst_n, .i_en(w_adv),
        .i_valid(w_pvalid), .i_n(w_n), .i_t3(w_t3), .i_side(w_pside),
        .o_valid(w_dvalid), .o_res(w_dres)
    );

    cji_outq u_outq (
        .i_clk, .i_rst_n,
        .i_push(w_dvalid & w_adv), .i_data(w_dres), .i_ready(i_out_ready),
        .o_valid(o_out_valid), .o_data(w_ores), .o_room(w_adv)
    );

    assign o_in_ready = w_adv;
    assign o_position = w_ores.position;
    assign o_overflow = w_ores.overflow;

endmodule

/* hdl/cji_chk.sv */
// ---------------------------------------------------------------------------
// cji_chk
// Port-level checks of the cubic joint interpolator.
// ---------------------------------------------------------------------------
module cji_chk import cji_pkg::*; (
    input logic                    i_clk,
    input logic                    i_rst_n,
    input logic                    i_cfg_we,
    input logic [TIME_BITS-1:0]    i_cfg_wdata,
    input logic                    i_in_valid,
    input logic                    o_in_ready,
    input logic signed [POS_W-1:0] i_start_position,
    input logic signed [POS_W-1:0] i_target_position,
    input logic signed [POS_W-1:0] i_start_velocity,
    input logic signed [POS_W-1:0] i_end_velocity,
    input logic [TIME_BITS-1:0]    i_elapsed_time,
    input logic                    o_out_valid,
    input logic                    i_out_ready,
    input logic signed [POS_W-1:0] o_position,
    input logic                    o_overflow
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=>
            o_out_valid && $stable(o_position) && $stable(o_overflow))
        else $error("result changed while stalled");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && o_in_ready)
        else $error("result or stall after reset");

    a_ovf_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_overflow |->
            (o_position == POS_MAX) || (o_position == POS_MIN))
        else $error("overflow without saturated position");

    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> o_out_valid)
        else $error("input stalled with no result pending");

endmodule

bind cubic_joint_interpolator cji_chk u_cji_chk (.*);

/* tb/cubic_joint_interpolator_test.sv */
// ---------------------------------------------------------------------------
// cubic_joint_interpolator_test
// Self-checking bench for the cubic Hermite joint interpolator. A directed
// table covers the segment endpoints and the extremes of every field. It is
// followed by random joint moves under several move durations, including
// zero, the shortest and the longest. Every output is compared in order to
// a stored result or an exact wide-integer evaluation of the segment.
// ---------------------------------------------------------------------------
module cubic_joint_interpolator_test;
    import cji_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int DRAIN_CYCLES = 64;
    localparam int STALL_LIMIT  = 4000;

    typedef struct {
        logic signed [POS_W-1:0] p0;
        logic signed [POS_W-1:0] p1;
        logic signed [POS_W-1:0] v0;
        logic signed [POS_W-1:0] v1;
        logic [TIME_BITS-1:0]    t;
        bit                      typed;
        t_res                    want;
    } t_move;

    logic                    i_clk = 1'b0;
    logic                    i_rst_n = 1'b0;
    logic                    i_cfg_we = 1'b0;
    logic [TIME_BITS-1:0]    i_cfg_wdata = '0;
    logic                    i_in_valid = 1'b0;
    logic                    o_in_ready;
    logic signed [POS_W-1:0] i_start_position = '0;
    logic signed [POS_W-1:0] i_target_position = '0;
    logic signed [POS_W-1:0] i_start_velocity = '0;
    logic signed [POS_W-1:0] i_end_velocity = '0;
    logic [TIME_BITS-1:0]    i_elapsed_time = '0;
    logic                    o_out_valid;
    logic                    i_out_ready = 1'b0;
    logic signed [POS_W-1:0] o_position;
    logic                    o_overflow;

    logic [TIME_BITS-1:0] move_duration = DURATION_RESET;
    t_res                 pending_positions[$];
    int                   mismatches = 0;
    int                   quiet_cycles = 0;
    int                   rx_hold = 0;
    bit                   calm = 1'b0;

    cubic_joint_interpolator DUT (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_wdata       (i_cfg_wdata),
        .i_in_valid        (i_in_valid),
        .o_in_ready        (o_in_ready),
        .i_start_position  (i_start_position),
        .i_target_position (i_target_position),
        .i_start_velocity  (i_start_velocity),
        .i_end_velocity    (i_end_velocity),
        .i_elapsed_time    (i_elapsed_time),
        .o_out_valid       (o_out_valid),
        .i_out_ready       (i_out_ready),
        .o_position        (o_position),
        .o_overflow        (o_overflow)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // exact Hermite evaluation, round half up, saturate to 32 bits
    function automatic t_res hermite_position(t_move m, logic [TIME_BITS-1:0] dur);
        logic signed [255:0] bp0, dp, bv0, bv1, bt, bd, d2, d3, t2, t3, num, den, q;
        t_res r;
        r.overflow = 1'b0;
        if (dur == 0) begin
            r.position = m.p1;
            return r;
        end
        bp0 = m.p0;
        dp  = m.p1;
        dp  = dp - bp0;
        bv0 = m.v0;
        bv1 = m.v1;
        bt  = {232'd0, m.t};
        bd  = {232'd0, dur};
        d2  = bd * bd;
        d3  = d2 * bd;
        t2  = bt * bt;
        t3  = t2 * bt;
        num = (bp0 * d3 + 3 * dp * t2 * bd - 2 * dp * t3) <<< TIME_FRAC_BITS;
        num = num + bv0 * bt * d3 + (-2 * bv0 - bv1) * d2 * t2 + (bv0 + bv1) * bd * t3;
        den = d3 <<< TIME_FRAC_BITS;
        num = num + (den >>> 1);
        if (num < 0)
            q = -((-num + den - 1) / den);
        else
            q = num / den;
        if (q > 256'sh7FFFFFFF) begin
            r.position = POS_MAX;
            r.overflow = 1'b1;
        end else if (q < -256'sh80000000) begin
            r.position = POS_MIN;
            r.overflow = 1'b1;
        end else begin
            r.position = q[POS_W-1:0];
        end
        return r;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        mismatches++;
    endtask

    // caller is at a rising edge; returns at the edge of acceptance
    task automatic send_move(t_move m);
        i_in_valid        <= 1'b1;
        i_start_position  <= m.p0;
        i_target_position <= m.p1;
        i_start_velocity  <= m.v0;
        i_end_velocity    <= m.v1;
        i_elapsed_time    <= m.t;
        do @(posedge i_clk); while (!o_in_ready);
        pending_positions = {pending_positions,
                             (m.typed ? m.want : hermite_position(m, move_duration))};
    endtask

    task automatic maybe_idle();
        if (!calm && $urandom_range(0, 5) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge i_clk);
        end
    endtask

    task automatic set_duration(logic [TIME_BITS-1:0] v);
        i_in_valid <= 1'b0;
        while (pending_positions.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        move_duration = v;
    endtask

    function automatic logic signed [POS_W-1:0] rand_pos();
        case ($urandom_range(0, 7))
            0: return POS_MAX;
            1: return POS_MIN;
            2: return '0;
            3: return $signed(32'($urandom_range(0, 2000)) - 32'sd1000) <<< 16;
            default: return $urandom;
        endcase
    endfunction

    function automatic t_move rand_move(logic [TIME_BITS-1:0] dur);
        t_move m;
        longint span;
        m.p0 = rand_pos();
        m.p1 = rand_pos();
        m.v0 = rand_pos();
        m.v1 = rand_pos();
        span = 2 * longint'(dur);
        if (span > 24'hFFFFFF) span = 24'hFFFFFF;
        case ($urandom_range(0, 5))
            0: m.t = TIME_BITS'($urandom);
            1: m.t = dur;
            2: m.t = '0;
            default: m.t = TIME_BITS'($urandom_range(0, int'(span)));
        endcase
        m.typed = 1'b0;
        m.want  = '0;
        return m;
    endfunction

    t_move directed[] = '{
        '{32'sd0, 32'sd0, 32'sd0, 32'sd0, 24'd0, 1'b1, '{32'sd0, 1'b0}},
        '{32'sd65536, -32'sd65536, 32'sd0, 32'sd0, 24'd0, 1'b1, '{32'sd65536, 1'b0}},
        '{32'sd65536, -32'sd65536, 32'sd1000, -32'sd7, 24'd65536, 1'b1,
          '{-32'sd65536, 1'b0}},
        '{32'h7FFFFFFF, 32'sh80000000, 32'h7FFFFFFF, 32'sh80000000, 24'd0, 1'b1,
          '{32'h7FFFFFFF, 1'b0}},
        '{32'sh80000000, 32'h7FFFFFFF, 32'sh80000000, 32'h7FFFFFFF, 24'd65536, 1'b1,
          '{32'h7FFFFFFF, 1'b0}},
        '{32'sh80000000, 32'h7FFFFFFF, 32'sh80000000, 32'h7FFFFFFF, 24'd0, 1'b1,
          '{32'sh80000000, 1'b0}},
        '{32'sd0, 32'sd0, 32'h7FFFFFFF, 32'h7FFFFFFF, 24'hFFFFFF, 1'b0, '0},
        '{32'sd0, 32'sd0, 32'sh80000000, 32'sh80000000, 24'hFFFFFF, 1'b0, '0},
        '{32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'sd0, 24'd131072, 1'b0, '0},
        '{32'sh80000000, 32'sh80000000, 32'sh80000000, 32'sd0, 24'd131072, 1'b0, '0},
        '{32'sd0, 32'sd655360, 32'sd0, 32'sd0, 24'd32768, 1'b0, '0},
        '{32'sd0, 32'sd1, 32'sd0, 32'sd0, 24'd32768, 1'b0, '0},
        '{32'sd0, -32'sd1, 32'sd0, 32'sd0, 24'd32768, 1'b0, '0},
        '{32'sd12345, 32'sd54321, 32'sd65536, -32'sd65536, 24'd1, 1'b0, '0},
        '{32'sd12345, 32'sd54321, 32'sd65536, -32'sd65536, 24'd65535, 1'b0, '0},
        '{32'sd0, 32'h7FFFFFFF, 32'sd0, 32'sd0, 24'hFFFFFF, 1'b0, '0},
        '{32'h55555555, 32'sh2AAAAAAA, 32'shAAAAAAAA, 32'h55555555, 24'hAAAAAA, 1'b0, '0},
        '{32'shAAAAAAAA, 32'h55555555, 32'h55555555, 32'shAAAAAAAA, 24'h555555, 1'b0, '0}
    };

    logic [TIME_BITS-1:0] durations[] = '{
        24'd1, 24'd0, 24'hFFFFFF, 24'd196608, 24'd200, 24'd65536, 24'd0
    };

    // receiver: random stall bursts, checking, watchdog
    always @(posedge i_clk) begin
        t_res want;
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            if (calm) begin
                i_out_ready <= 1'b1;
            end else if (rx_hold > 0) begin
                rx_hold--;
                i_out_ready <= 1'b0;
            end else if ($urandom_range(0, 9) == 0) begin
                rx_hold = $urandom_range(0, 13);
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= 1'b1;
            end
            if (o_out_valid && i_out_ready) begin
                if (pending_positions.size() == 0) begin
                    report_mismatch("unexpected transaction position", o_position, 0);
                end else begin
                    want = pending_positions.pop_front();
                    if (o_position !== want.position)
                        report_mismatch("position", o_position, want.position);
                    if (o_overflow !== want.overflow)
                        report_mismatch("overflow", o_overflow, want.overflow);
                end
            end
            if ((o_out_valid && i_out_ready) || (i_in_valid && o_in_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("[FAIL] regression broken");
                $finish;
            end
        end
    end

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        foreach (directed[i]) begin
            send_move(directed[i]);
            maybe_idle();
        end
        for (int i = 0; i < 100; i++) begin
            send_move(rand_move(move_duration));
            maybe_idle();
        end
        foreach (durations[k]) begin
            if (k == durations.size() - 1) calm = 1'b1;
            set_duration(durations[k]);
            for (int i = 0; i < 105; i++) begin
                send_move(rand_move(move_duration));
                maybe_idle();
            end
        end
        i_in_valid <= 1'b0;
        while (pending_positions.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
